FILE: sv/base64_stream_encoder_top_assert.svh
// Assertion macros shared by the base64 stream encoder modules
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define B64E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e check failed");

// Next-cycle implication, sampled on clk, off during reset
`define B64E_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e check failed");

`endif

FILE: sv/b64e_pkg.sv
// Shared types, constants and the sextet-to-ASCII mapping for the base64 encoder
`default_nettype none

package b64e_pkg;

    // Group queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Number of trailing '=' characters in a group
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } pad_t;

    // One encode request: 24 bits of group data plus framing
    typedef struct packed {
        logic [23:0] bits;
        pad_t        pad;
        logic        last;
    } group_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
            begin
                c = w + 8'd65;
            end
            else if (v < 6'd52)
            begin
                c = w + 8'd71;
            end
            else if (v < 6'd62)
            begin
                c = w - 8'd4;
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/b64e_front.sv
// Front end: gathers raw bytes into groups and classifies them for encoding
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       q_full,
    output logic            full,
    output logic            q_wr,
    output group_t          q_entry
);

    logic [15:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic        accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify the incoming byte against the pending state
    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        q_wr               = 1'b0;
        q_entry.bits       = {pending_bytes_reg, data_byte};
        q_entry.pad        = PAD_NONE;
        q_entry.last       = final_byte;
        if (accept)
        begin
            if (pending_count_reg >= 2'd2)
            begin
                // full group of three bytes
                q_wr               = 1'b1;
                pending_bytes_next = '0;
                pending_count_next = '0;
            end
            else if (!final_byte)
            begin
                // hold byte, no output yet
                if (pending_count_reg == 2'd0)
                begin
                    pending_bytes_next = {data_byte, 8'h00};
                end
                else
                begin
                    pending_bytes_next = {pending_bytes_reg[15:8], data_byte};
                end
                pending_count_next = pending_count_reg + 2'd1;
            end
            else
            begin
                // short final group, padded
                q_wr = 1'b1;
                if (pending_count_reg == 2'd0)
                begin
                    q_entry.bits = {data_byte, 16'h0000};
                    q_entry.pad  = PAD_TWO;
                end
                else
                begin
                    q_entry.bits = {pending_bytes_reg[15:8], data_byte, 8'h00};
                    q_entry.pad  = PAD_ONE;
                end
                pending_bytes_next = '0;
                pending_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= '0;
            pending_count_reg <= '0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/b64e_queue.sv
// Short queue of encode requests between the front end and the character stage
`default_nettype none

`include "base64_stream_encoder_top_assert.svh"

module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire group_t wr_entry,
    input  wire logic   rd,
    output group_t      rd_entry,
    output logic        q_full,
    output logic        q_empty
);

    group_t               entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_full   = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign rd_entry = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    `B64E_ASSERT_IMP(a_no_overflow, wr && !rd, !q_full)
    `B64E_ASSERT_IMP(a_no_underflow, rd, !q_empty)
    `B64E_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

`default_nettype wire

FILE: sv/b64e_back.sv
// Back end: turns each encode request into four characters, one per cycle while pop keeps up
`default_nettype none

`include "base64_stream_encoder_top_assert.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire group_t     rd_entry,
    output logic            q_rd,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      out_char,
    output logic            last_char
);

    group_t      cur_reg, cur_next;
    logic        busy_reg, busy_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        last_reg, last_next;

    logic        pop_acc;
    logic        emit;
    logic        end_group;
    logic        is_pad;
    logic [5:0]  sextet;

    assign pop_acc   = pop && out_valid_reg;
    assign emit      = busy_reg && (!out_valid_reg || pop_acc);
    assign end_group = emit && (idx_reg == 2'd3);
    assign q_rd      = !q_empty && (!busy_reg || end_group);

    // Sextet select, most significant first
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = cur_reg.bits[23:18];
            2'd1:    sextet = cur_reg.bits[17:12];
            2'd2:    sextet = cur_reg.bits[11:6];
            default: sextet = cur_reg.bits[5:0];
        endcase
    end

    // Trailing positions become '=' per the pad count
    assign is_pad = ((idx_reg == 2'd3) && (cur_reg.pad != PAD_NONE))
                 || ((idx_reg == 2'd2) && (cur_reg.pad == PAD_TWO));

    // Group sequencing and output register update
    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (pop_acc)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = is_pad ? PAD_CHAR : sextet_to_ascii(sextet);
            last_next      = cur_reg.last && (idx_reg == 2'd3);
            idx_next       = idx_reg + 2'd1;
        end
        if (end_group)
        begin
            busy_next = 1'b0;
        end
        if (q_rd)
        begin
            cur_next  = rd_entry;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign empty     = !out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

    `B64E_ASSERT_IMP(a_idle_idx_zero, !busy_reg, idx_reg == 2'd0)
    `B64E_ASSERT_NXT(a_group_done_idle, end_group && !q_rd, !busy_reg)
    `B64E_ASSERT_NXT(a_hold_out, out_valid_reg && !pop, out_valid_reg && $stable(out_char_reg))

endmodule

`default_nettype wire

FILE: sv/base64_stream_encoder_top.sv
// Top level of the streaming base64 encoder: front end, request queue, character stage
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------
//   input    | push / full        | data_byte[7:0], final_byte
//   result   | empty / pop        | out_char[7:0], last_char
//
// A byte is accepted every cycle while the two-entry request queue has room.
// The character stage emits one character per cycle while pop keeps up, so a
// steady stream runs at four characters per three bytes.
// The first character of a group passes the queue, group and output registers.
// A stalled pop holds the output register; the queue absorbs the front end.
// Reset (rst_n low) clears pending bytes, queue pointers and the output valid flag.
`default_nettype none

module base64_stream_encoder_top
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_char,
    output logic            last_char
);

    group_t wr_entry;
    group_t rd_entry;
    logic   q_wr;
    logic   q_rd;
    logic   q_full;
    logic   q_empty;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .full       (full),
        .q_wr       (q_wr),
        .q_entry    (wr_entry)
    );

    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (wr_entry),
        .rd       (q_rd),
        .rd_entry (rd_entry),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .rd_entry  (rd_entry),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

`default_nettype wire
